### rtl/core/wfdc_pkg.sv
// ----------------------------------------------------------------------------
// wfdc_pkg
// Types, constants and codes shared by the wall following drive controller.
// ----------------------------------------------------------------------------
package wfdc_pkg;

    // default tuning, overridable on the top level
    localparam int MAX_SPEED_DEF = 255;
    localparam int STOP_BAND_DEF = 10;

    // fixed geometry and drive limits
    localparam int WALL_SET_MM   = 65;
    localparam int WALL_SEEN_MM  = 300;
    localparam int FRONT_STOP_MM = 100;
    localparam int MIN_DRIVE     = 110;

    // field widths
    localparam int CNT_W    = 24;
    localparam int TGT_W    = 23;
    localparam int GAIN_W   = 16;
    localparam int HDG_W    = 13;
    localparam int RNG_W    = 13;
    localparam int ERR_W    = 25;   // target minus count
    localparam int WERR_W   = 15;   // wall error in mm
    localparam int PD_W     = 18;   // clamped wheel PD, scale 2^8
    localparam int YAW_W    = 39;   // yaw correction, scale 2^12
    localparam int NUM_W    = 40;   // wheel speed before the 2^12 divide
    localparam int PWM_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 23;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        DIR_OFF = 2'd0,
        DIR_FWD = 2'd1,
        DIR_REV = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        STOP_NONE     = 2'd0,
        STOP_OBSTACLE = 2'd1,
        STOP_DISTANCE = 2'd2
    } t_stop;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_COUNTS = 3'd0,
        CFG_KP_LEFT       = 3'd1,
        CFG_KD_LEFT       = 3'd2,
        CFG_KP_RIGHT      = 3'd3,
        CFG_KD_RIGHT      = 3'd4,
        CFG_KP_WALL       = 3'd5,
        CFG_KD_WALL       = 3'd6,
        CFG_KP_HEADING    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] kd;
    } t_pd_gain;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_wall;
        logic [GAIN_W-1:0] kd_wall;
        logic [GAIN_W-1:0] kp_heading;
    } t_yaw_gain;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [PD_W-1:0]  pd;
    } t_wheel_res;

    typedef struct packed {
        logic                    start_req;
        logic signed [CNT_W-1:0] count_left;
        logic signed [CNT_W-1:0] count_right;
        logic signed [HDG_W-1:0] heading;
        logic signed [HDG_W-1:0] target_heading;
        logic [RNG_W-1:0]        range_left;
        logic [RNG_W-1:0]        range_right;
        logic [RNG_W-1:0]        range_front;
    } t_tick;

    typedef struct packed {
        logic [PWM_W-1:0] pwm_left;
        t_dir             dir_left;
        logic [PWM_W-1:0] pwm_right;
        t_dir             dir_right;
        t_stop            stop_cause;
    } t_result;

endpackage

### rtl/core/wfdc_wheel_pd.sv
// ----------------------------------------------------------------------------
// wfdc_wheel_pd
// Count error and clamped PD term for one wheel, scale 2^8.
// ----------------------------------------------------------------------------
module wfdc_wheel_pd
    import wfdc_pkg::*;
#(
    parameter int MAX_SPEED = MAX_SPEED_DEF
) (
    input  logic [TGT_W-1:0]        i_target,
    input  logic signed [CNT_W-1:0] i_count,
    input  logic signed [ERR_W-1:0] i_last_err,
    input  t_pd_gain                i_gain,
    output t_wheel_res              o_res
);

    localparam int LIM = MAX_SPEED * 256;
    localparam logic signed [43:0] LIM_HI = 44'(LIM);
    localparam logic signed [43:0] LIM_LO = -44'(LIM);

    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W:0]   err_d;
    logic signed [41:0]      p_term;
    logic signed [42:0]      d_term;
    logic signed [43:0]      pd_sum;

    assign err    = $signed({2'b00, i_target}) - ERR_W'(i_count);
    assign err_d  = (ERR_W+1)'(err) - (ERR_W+1)'(i_last_err);
    assign p_term = $signed({1'b0, i_gain.kp}) * err;
    assign d_term = $signed({1'b0, i_gain.kd}) * err_d;
    assign pd_sum = 44'(p_term) + 44'(d_term);

    always_comb begin
        o_res.err = err;
        if (pd_sum > LIM_HI) begin
            o_res.pd = PD_W'(LIM_HI);
        end else if (pd_sum < LIM_LO) begin
            o_res.pd = PD_W'(LIM_LO);
        end else begin
            o_res.pd = PD_W'(pd_sum);
        end
    end

endmodule

### rtl/core/wfdc_yaw.sv
// ----------------------------------------------------------------------------
// wfdc_yaw
// Wall error from the side ranges and the yaw correction, scale 2^12.
// ----------------------------------------------------------------------------
module wfdc_yaw
    import wfdc_pkg::*;
(
    input  logic signed [HDG_W-1:0]  i_heading,
    input  logic signed [HDG_W-1:0]  i_target_heading,
    input  logic [RNG_W-1:0]         i_range_left,
    input  logic [RNG_W-1:0]         i_range_right,
    input  logic signed [WERR_W-1:0] i_last_we,
    input  t_yaw_gain                i_gain,
    output logic signed [WERR_W-1:0] o_we,
    output logic signed [YAW_W-1:0]  o_yaw
);

    localparam logic [RNG_W-1:0]  SEEN = RNG_W'(WALL_SEEN_MM);
    localparam logic signed [WERR_W-1:0] SETP = WERR_W'(WALL_SET_MM);

    logic                     wall_l;
    logic                     wall_r;
    logic signed [WERR_W-1:0] rl_s;
    logic signed [WERR_W-1:0] rr_s;
    logic signed [WERR_W-1:0] we;
    logic signed [WERR_W:0]   we_d;
    logic signed [HDG_W:0]    hd_diff;
    logic signed [30:0]       p_head;
    logic signed [31:0]       p_wall;
    logic signed [32:0]       d_wall;
    logic signed [33:0]       wall_sum;

    assign wall_l = (i_range_left != '0) && (i_range_left < SEEN);
    assign wall_r = (i_range_right != '0) && (i_range_right < SEEN);
    assign rl_s   = $signed({2'b00, i_range_left});
    assign rr_s   = $signed({2'b00, i_range_right});

    always_comb begin
        if (wall_l && wall_r) begin
            we = rl_s - rr_s;
        end else if (wall_l) begin
            we = rl_s - SETP;
        end else if (wall_r) begin
            we = rr_s - SETP;
        end else begin
            we = '0;
        end
    end

    assign we_d     = (WERR_W+1)'(we) - (WERR_W+1)'(i_last_we);
    assign hd_diff  = (HDG_W+1)'(i_heading) - (HDG_W+1)'(i_target_heading);
    assign p_head   = $signed({1'b0, i_gain.kp_heading}) * hd_diff;
    assign p_wall   = $signed({1'b0, i_gain.kp_wall}) * we;
    assign d_wall   = $signed({1'b0, i_gain.kd_wall}) * we_d;
    assign wall_sum = 34'(p_wall) + 34'(d_wall);

    assign o_we  = we;
    assign o_yaw = YAW_W'(p_head) + (YAW_W'(wall_sum) <<< 4);

endmodule

### rtl/core/wfdc_drive.sv
// ----------------------------------------------------------------------------
// wfdc_drive
// Scale one wheel speed down by 2^12, apply the minimum and maximum duty
// and split it into duty magnitude and direction.
// ----------------------------------------------------------------------------
module wfdc_drive
    import wfdc_pkg::*;
#(
    parameter int MAX_SPEED = MAX_SPEED_DEF
) (
    input  logic signed [NUM_W-1:0] i_num,
    output logic [PWM_W-1:0]        o_pwm,
    output t_dir                    o_dir
);

    localparam int Q_W = NUM_W - 12;
    localparam logic [Q_W-1:0] MIN_MAG = Q_W'(MIN_DRIVE);
    localparam logic [Q_W-1:0] MAX_MAG = Q_W'(MAX_SPEED);

    logic signed [NUM_W-1:0] adj;
    logic signed [Q_W-1:0]   quo;
    logic [Q_W-1:0]          mag;
    logic [Q_W-1:0]          mag_lim;

    // bias negative values so the shift truncates toward zero
    assign adj = i_num + (i_num[NUM_W-1] ? NUM_W'(4095) : '0);
    assign quo = adj[NUM_W-1:12];
    assign mag = quo[Q_W-1] ? Q_W'(-quo) : Q_W'(quo);

    always_comb begin
        mag_lim = mag;
        if ((mag != '0) && (mag < MIN_MAG)) begin
            mag_lim = MIN_MAG;
        end
        if (mag_lim > MAX_MAG) begin
            mag_lim = MAX_MAG;
        end
        if (quo == '0) begin
            o_dir = DIR_OFF;
        end else if (quo[Q_W-1]) begin
            o_dir = DIR_REV;
        end else begin
            o_dir = DIR_FWD;
        end
    end

    assign o_pwm = mag_lim[PWM_W-1:0];

endmodule

### rtl/core/wall_following_drive_controller.sv
// ----------------------------------------------------------------------------
// wall_following_drive_controller
// One control tick of a straight move: wheel PD on count error, yaw
// correction from heading and side walls, obstacle and arrival braking.
// ----------------------------------------------------------------------------
// Result path: an input transfer loads the tick register, and the result
//   register takes the result computed from it on a pipeline advance.
// Throughput: one tick per cycle; the tick register feeds one pass of
//   parallel multipliers into the result register, stalled only by tready.
// Reset (synchronous, active low) clears valids, configuration registers and stored errors.
// ----------------------------------------------------------------------------
module wall_following_drive_controller
    import wfdc_pkg::*;
#(
    parameter int MAX_SPEED = MAX_SPEED_DEF,
    parameter int STOP_BAND = STOP_BAND_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_DAT_W-1:0]   i_cfg_wdata,
    // tick stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // count_left[23:0], count_right[47:24], heading[60:48],
    // target_heading[73:61], range_left[86:74], range_right[99:87],
    // range_front[112:100], zero fill[119:113]
    input  logic [S_TDATA_W-1:0]   i_s_axis_tdata,
    // start_req[0]
    input  logic [0:0]             i_s_axis_tuser,
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // pwm_left[7:0], dir_left[9:8], pwm_right[17:10], dir_right[19:18],
    // stop_cause[21:20], zero fill[23:22]
    output logic [M_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam logic [ERR_W:0] STOP_SUM = (ERR_W+1)'(2 * STOP_BAND);
    localparam logic [RNG_W-1:0] FRONT_LIM = RNG_W'(FRONT_STOP_MM);

    // configuration registers
    logic [TGT_W-1:0]  r_target_counts;
    logic [GAIN_W-1:0] r_kp_left, r_kd_left, r_kp_right, r_kd_right;
    logic [GAIN_W-1:0] r_kp_wall, r_kd_wall, r_kp_heading;

    // pipeline
    logic    r_in_valid;
    t_tick   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;
    logic    fire;

    // stored errors
    logic signed [ERR_W-1:0]  r_last_err_l, r_last_err_r;
    logic signed [WERR_W-1:0] r_last_we;
    logic signed [ERR_W-1:0]  last_l, last_r;
    logic signed [WERR_W-1:0] last_we;

    t_pd_gain                gain_l, gain_r;
    t_yaw_gain               gain_y;
    t_wheel_res              wheel_l, wheel_r;
    logic signed [WERR_W-1:0] we;
    logic signed [YAW_W-1:0] yaw;
    logic signed [NUM_W-1:0] num_l, num_r;
    logic [PWM_W-1:0]        pwm_l, pwm_r;
    t_dir                    dir_l, dir_r;
    logic [ERR_W-1:0]        abs_l, abs_r;
    logic [ERR_W:0]          abs_sum;
    logic                    obstacle;
    logic                    arrived;
    t_result                 n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_counts <= '0;
            r_kp_left       <= '0;
            r_kd_left       <= '0;
            r_kp_right      <= '0;
            r_kd_right      <= '0;
            r_kp_wall       <= '0;
            r_kd_wall       <= '0;
            r_kp_heading    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_TARGET_COUNTS: r_target_counts <= i_cfg_wdata[TGT_W-1:0];
                CFG_KP_LEFT:       r_kp_left       <= i_cfg_wdata[GAIN_W-1:0];
                CFG_KD_LEFT:       r_kd_left       <= i_cfg_wdata[GAIN_W-1:0];
                CFG_KP_RIGHT:      r_kp_right      <= i_cfg_wdata[GAIN_W-1:0];
                CFG_KD_RIGHT:      r_kd_right      <= i_cfg_wdata[GAIN_W-1:0];
                CFG_KP_WALL:       r_kp_wall       <= i_cfg_wdata[GAIN_W-1:0];
                CFG_KD_WALL:       r_kd_wall       <= i_cfg_wdata[GAIN_W-1:0];
                CFG_KP_HEADING:    r_kp_heading    <= i_cfg_wdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // the result register moves whenever it is empty or being drained
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.start_req      <= i_s_axis_tuser[0];
            r_in.count_left     <= i_s_axis_tdata[23:0];
            r_in.count_right    <= i_s_axis_tdata[47:24];
            r_in.heading        <= i_s_axis_tdata[60:48];
            r_in.target_heading <= i_s_axis_tdata[73:61];
            r_in.range_left     <= i_s_axis_tdata[86:74];
            r_in.range_right    <= i_s_axis_tdata[99:87];
            r_in.range_front    <= i_s_axis_tdata[112:100];
        end
    end

    // a move start drops the stored errors before this tick uses them
    assign last_l  = r_in.start_req ? '0 : r_last_err_l;
    assign last_r  = r_in.start_req ? '0 : r_last_err_r;
    assign last_we = r_in.start_req ? '0 : r_last_we;

    assign gain_l = '{kp: r_kp_left, kd: r_kd_left};
    assign gain_r = '{kp: r_kp_right, kd: r_kd_right};
    assign gain_y = '{kp_wall: r_kp_wall, kd_wall: r_kd_wall, kp_heading: r_kp_heading};

    wfdc_wheel_pd #(
        .MAX_SPEED (MAX_SPEED)
    ) u_pd_left (
        .i_target   (r_target_counts),
        .i_count    (r_in.count_left),
        .i_last_err (last_l),
        .i_gain     (gain_l),
        .o_res      (wheel_l)
    );

    wfdc_wheel_pd #(
        .MAX_SPEED (MAX_SPEED)
    ) u_pd_right (
        .i_target   (r_target_counts),
        .i_count    (r_in.count_right),
        .i_last_err (last_r),
        .i_gain     (gain_r),
        .o_res      (wheel_r)
    );

    wfdc_yaw u_yaw (
        .i_heading        (r_in.heading),
        .i_target_heading (r_in.target_heading),
        .i_range_left     (r_in.range_left),
        .i_range_right    (r_in.range_right),
        .i_last_we        (last_we),
        .i_gain           (gain_y),
        .o_we             (we),
        .o_yaw            (yaw)
    );

    assign num_l = (NUM_W'(wheel_l.pd) <<< 4) - NUM_W'(yaw);
    assign num_r = (NUM_W'(wheel_r.pd) <<< 4) + NUM_W'(yaw);

    wfdc_drive #(
        .MAX_SPEED (MAX_SPEED)
    ) u_drive_left (
        .i_num (num_l),
        .o_pwm (pwm_l),
        .o_dir (dir_l)
    );

    wfdc_drive #(
        .MAX_SPEED (MAX_SPEED)
    ) u_drive_right (
        .i_num (num_r),
        .o_pwm (pwm_r),
        .o_dir (dir_r)
    );

    assign abs_l    = wheel_l.err[ERR_W-1] ? ERR_W'(-wheel_l.err) : ERR_W'(wheel_l.err);
    assign abs_r    = wheel_r.err[ERR_W-1] ? ERR_W'(-wheel_r.err) : ERR_W'(wheel_r.err);
    assign abs_sum  = (ERR_W+1)'(abs_l) + (ERR_W+1)'(abs_r);
    assign obstacle = (r_in.range_front != '0) && (r_in.range_front < FRONT_LIM);
    assign arrived  = abs_sum < STOP_SUM;

    always_comb begin
        n_out = '{pwm_left: '0, dir_left: DIR_OFF, pwm_right: '0,
                  dir_right: DIR_OFF, stop_cause: STOP_NONE};
        if (obstacle) begin
            n_out.stop_cause = STOP_OBSTACLE;
        end else if (arrived) begin
            n_out.stop_cause = STOP_DISTANCE;
        end else begin
            n_out.pwm_left  = pwm_l;
            n_out.dir_left  = dir_l;
            n_out.pwm_right = pwm_r;
            n_out.dir_right = dir_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_last_err_l <= '0;
            r_last_err_r <= '0;
            r_last_we    <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_last_we <= we;
                // hold the count errors across a braked tick
                if (!obstacle && !arrived) begin
                    r_last_err_l <= wheel_l.err;
                    r_last_err_r <= wheel_r.err;
                end else begin
                    r_last_err_l <= last_l;
                    r_last_err_r <= last_r;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.stop_cause, r_out.dir_right, r_out.pwm_right,
                              r_out.dir_left, r_out.pwm_left};

    // braked results carry no drive
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stop_cause != STOP_NONE) |->
        (r_out.pwm_left == '0 && r_out.pwm_right == '0 &&
         r_out.dir_left == DIR_OFF && r_out.dir_right == DIR_OFF))
        else $error("braked result carries drive");

    // duty is zero exactly when the wheel is off
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
        ((r_out.dir_left == DIR_OFF) == (r_out.pwm_left == '0)) &&
        ((r_out.dir_right == DIR_OFF) == (r_out.pwm_right == '0)))
        else $error("direction and duty disagree");

    // running left duty stays within the drive limits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.pwm_left != '0) |->
        (r_out.pwm_left <= PWM_W'(MAX_SPEED) &&
         (r_out.pwm_left >= PWM_W'(MIN_DRIVE) || r_out.pwm_left == PWM_W'(MAX_SPEED))))
        else $error("left duty outside drive limits");

    // a braked tick without a move start keeps the stored count errors
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_in.start_req && (obstacle || arrived)) |=>
        ($stable(r_last_err_l) && $stable(r_last_err_r)))
        else $error("count errors stored on braked tick");

    // while the result is stalled it stays valid and the stored wall error holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_last_we)))
        else $error("state moved while result stalled");

endmodule
